>>> src/pidga_pkg.sv
// Shared types, constants and helpers for the PID gain advisor.
// Holds the item formats, gain factors and thresholds; no dependencies.
package pidga_pkg;

	// Fixed thresholds on Q16.16 metrics
	localparam logic [31:0] LIM_EXCELLENT   = 32'd19661;
	localparam logic [31:0] LIM_SPREAD_DONE = 32'd32768;
	localparam logic [31:0] LIM_GOOD        = 32'd65536;
	localparam logic [31:0] LIM_PEAK        = 32'd327680;
	localparam logic [31:0] FLOOR_P         = 32'd655;
	localparam logic [31:0] FLOOR_I         = 32'd66;

	// Gain factors, Q2.30
	localparam logic [31:0] F_085 = 32'd912680550;
	localparam logic [31:0] F_090 = 32'd966367642;
	localparam logic [31:0] F_120 = 32'd1288490189;
	localparam logic [31:0] F_130 = 32'd1395864371;
	localparam logic [31:0] F_140 = 32'd1503238554;
	localparam logic [31:0] F_070 = 32'd751619277;
	localparam logic [31:0] F_080 = 32'd858993459;
	localparam logic [31:0] F_150 = 32'd1610612736;
	localparam logic [63:0] ROUND_HALF = 64'd536870912;

	// Score arithmetic, Q16.16
	localparam logic [22:0] SCORE_FULL   = 23'd6553600;
	localparam logic [22:0] SCORE_CHANGE = 23'd5242880;
	localparam logic [20:0] CAP_30       = 21'd1966080;
	localparam logic [20:0] CAP_20       = 21'd1310720;
	// rounded ITAE at or above this always hits the 20.0 cap
	localparam logic [32:0] ITAE_BIG     = 33'd131072000;
	localparam logic [32:0] ITAE_ROUND   = 33'd50;
	// ceil(2^34 / 100): exact quotient for inputs below 2^27
	localparam logic [27:0] RECIP_100    = 28'd171798692;

	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic [1:0] CFG_OSC_LIMIT    = 2'd0;
	localparam logic [1:0] CFG_SLOW_LIMIT   = 2'd1;
	localparam logic [1:0] CFG_STEADY_LIMIT = 2'd2;
	localparam logic [1:0] CFG_CAUTIOUS     = 2'd3;

	typedef enum logic [2:0] {
		ADV_EXCELLENT = 3'd0,
		ADV_GOOD      = 3'd1,
		ADV_OSC       = 3'd2,
		ADV_SLOW      = 3'd3,
		ADV_OFFSET    = 3'd4,
		ADV_NORMAL    = 3'd5
	} advice_t;

	typedef struct packed {
		logic [31:0] osc_limit;
		logic [31:0] slow_limit;
		logic [31:0] steady_limit;
		logic        cautious;
	} cfg_t;

	// Classified item handed from front to back
	typedef struct packed {
		logic [31:0] p0;
		logic [31:0] i0;
		logic [31:0] d0;
		logic [22:0] score;
		logic        done;
		logic        change;
		logic        osc;
		logic        slow;
		logic        offs;
		logic        over;
		advice_t     advice;
	} item_t;

	// Item plus gains under adjustment in the back pipeline
	typedef struct packed {
		item_t       it;
		logic [31:0] p;
		logic [31:0] i;
		logic [31:0] d;
	} work_t;

	// Round Q.46 product back to Q16.16, half up, saturating
	function automatic logic [31:0] round_sat(input logic [63:0] prod);
		logic [63:0] sum;
		begin
			sum = prod + ROUND_HALF;
			if (sum[63:62] != 2'b00) begin
				round_sat = '1;
			end else begin
				round_sat = sum[61:30];
			end
		end
	endfunction

endpackage

>>> src/pidga_queue.sv
// Small register FIFO between the classifier and the gain pipeline.
// Generic width and depth; no package dependencies.
module pidga_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output logic [WIDTH-1:0]           head_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	// storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign count      = count_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q != CW'(DEPTH)))
		else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue pop while empty");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");
endmodule

>>> src/pidga_front.sv
// Front end: accepts items, fires the rules, computes score and advice.
// Uses pidga_pkg; feeds pidga_queue with classified items.
module pidga_front #(
	parameter int DEPTH = pidga_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pidga_pkg::cfg_t            cfg,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [31:0]                mean_error,
	input  logic [31:0]                error_spread,
	input  logic [31:0]                peak_error,
	input  logic [31:0]                time_weighted_error,
	input  logic [31:0]                gain_p_now,
	input  logic [31:0]                gain_i_now,
	input  logic [31:0]                gain_d_now,
	input  logic [$clog2(DEPTH+1)-1:0] queue_count,
	output logic                       push,
	output pidga_pkg::item_t           push_item
);
	import pidga_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	logic        in_xfer;
	logic        v_s1;
	logic        v_s2;
	item_t       it_s1;
	item_t       it_s2;
	logic [20:0] d_mean_s1;
	logic [20:0] d_spread_s1;
	logic [20:0] d_peak_s1;
	logic [54:0] itae_prod_s1;
	logic        itae_big_s1;
	logic        itae_nz_s1;

	logic [35:0] mean_x10;
	logic [34:0] spread_x5;
	logic [32:0] peak_x2;
	logic [32:0] itae_rnd;
	logic        done_c;
	logic        slow_c;
	logic        osc_c;
	logic        steady_c;
	logic        over_c;
	advice_t     advice_c;
	item_t       it_c;

	logic [20:0] itae_quo;
	logic [20:0] d_itae;
	logic [22:0] ded;
	item_t       it2_c;

	// room for everything in flight plus the new item
	assign in_stall = ((CW+1)'(queue_count) + (CW+1)'(v_s1) + (CW+1)'(v_s2))
		>= (CW+1)'(DEPTH);
	assign in_xfer  = in_valid && !in_stall;

	// stage 1: rule checks and scaled deductions
	always_comb begin
		mean_x10  = {1'b0, mean_error, 3'b000} + {3'b000, mean_error, 1'b0};
		spread_x5 = {1'b0, error_spread, 2'b00} + {3'b000, error_spread};
		peak_x2   = {peak_error, 1'b0};
		itae_rnd  = {1'b0, time_weighted_error} + ITAE_ROUND;

		done_c   = (mean_error < LIM_EXCELLENT) && (error_spread < LIM_SPREAD_DONE);
		osc_c    = error_spread > cfg.osc_limit;
		slow_c   = mean_error > cfg.slow_limit;
		steady_c = mean_error > cfg.steady_limit;
		over_c   = ({1'b0, peak_error} > {mean_error, 1'b0}) && (peak_error > LIM_PEAK);

		if (mean_error < LIM_EXCELLENT) begin
			advice_c = ADV_EXCELLENT;
		end else if (mean_error < LIM_GOOD) begin
			advice_c = ADV_GOOD;
		end else if (osc_c) begin
			advice_c = ADV_OSC;
		end else if (slow_c) begin
			advice_c = ADV_SLOW;
		end else if (steady_c) begin
			advice_c = ADV_OFFSET;
		end else begin
			advice_c = ADV_NORMAL;
		end

		it_c        = '0;
		it_c.p0     = gain_p_now;
		it_c.i0     = gain_i_now;
		it_c.d0     = gain_d_now;
		it_c.done   = done_c;
		it_c.osc    = !done_c && osc_c;
		it_c.slow   = !done_c && slow_c;
		it_c.offs   = !done_c && !slow_c && steady_c;
		it_c.over   = !done_c && over_c;
		it_c.advice = advice_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_xfer;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		it_s1        <= it_c;
		d_mean_s1    <= (mean_x10 > 36'(CAP_30)) ? CAP_30 : mean_x10[20:0];
		d_spread_s1  <= (spread_x5 > 35'(CAP_30)) ? CAP_30 : spread_x5[20:0];
		d_peak_s1    <= (peak_x2 > 33'(CAP_20)) ? CAP_20 : peak_x2[20:0];
		itae_prod_s1 <= 55'(itae_rnd[26:0]) * 55'(RECIP_100);
		itae_big_s1  <= itae_rnd >= ITAE_BIG;
		itae_nz_s1   <= time_weighted_error != '0;
	end

	// stage 2: ITAE quotient, score and change flag
	always_comb begin
		itae_quo = itae_prod_s1[54:34];
		if (!itae_nz_s1) begin
			d_itae = '0;
		end else if (itae_big_s1 || (itae_quo > CAP_20)) begin
			d_itae = CAP_20;
		end else begin
			d_itae = itae_quo;
		end
		ded = 23'(d_mean_s1) + 23'(d_spread_s1) + 23'(d_peak_s1) + 23'(d_itae);

		it2_c        = it_s1;
		it2_c.score  = (ded >= SCORE_FULL) ? '0 : SCORE_FULL - ded;
		it2_c.change = (it2_c.score < SCORE_CHANGE)
			&& (it_s1.osc || it_s1.slow || it_s1.offs || it_s1.over);
	end

	always_ff @(posedge clk) begin
		it_s2 <= it2_c;
	end

	assign push      = v_s2;
	assign push_item = it_s2;
endmodule

>>> src/pidga_back.sv
// Back end: scales the gains through the rule chain and holds the result.
// Uses pidga_pkg; drains pidga_queue, drives the result channel.
module pidga_back (
	input  logic             clk,
	input  logic             arst_n,
	input  pidga_pkg::cfg_t  cfg,
	input  logic             head_valid,
	input  pidga_pkg::item_t head_item,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      gain_p_next,
	output logic [31:0]      gain_i_next,
	output logic [31:0]      gain_d_next,
	output logic [22:0]      quality_score,
	output logic             tuning_done,
	output logic             needs_change,
	output logic             oscillation_seen,
	output logic             slow_seen,
	output logic             offset_seen,
	output logic             overshoot_seen,
	output logic [2:0]       advice_code
);
	import pidga_pkg::*;

	logic        en;
	logic        mild;
	logic [5:0]  v_q;
	work_t       w_s1, w_s2, w_s3, w_s4, w_s5, w_s6;
	logic [63:0] prod_p_s1, prod_d_s1, prod_i_s1;
	logic [63:0] prod_p_s3;
	logic [63:0] prod_p_s5, prod_d_s5;
	work_t       w1_c, w2_c, w4_c, w6_c;
	logic [31:0] p_fin, i_fin, d_fin;
	logic [32:0] p_sum, i_sum, d_sum;

	logic        out_valid_q;
	logic [31:0] p_q, i_q, d_q;
	item_t       it_q;

	// whole pipe moves unless a finished result is held
	assign en   = !out_valid_q || !out_stall;
	assign pop  = en && head_valid;
	assign mild = cfg.cautious;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_q         <= {v_q[4:0], head_valid};
			out_valid_q <= v_q[5];
		end
	end

	// stage 1: oscillation and offset products
	always_comb begin
		w1_c    = '0;
		w1_c.it = head_item;
		w1_c.p  = head_item.p0;
		w1_c.i  = head_item.i0;
		w1_c.d  = head_item.d0;
	end

	// stage 2: pick oscillation and offset results
	always_comb begin
		w2_c = w_s1;
		if (w_s1.it.osc) begin
			w2_c.p = round_sat(prod_p_s1);
			w2_c.d = round_sat(prod_d_s1);
		end
		if (w_s1.it.offs) begin
			w2_c.i = round_sat(prod_i_s1);
		end
	end

	// stage 4: pick slow-response result
	always_comb begin
		w4_c = w_s3;
		if (w_s3.it.slow) begin
			w4_c.p = round_sat(prod_p_s3);
		end
	end

	// stage 6: pick overshoot result
	always_comb begin
		w6_c = w_s5;
		if (w_s5.it.over) begin
			w6_c.p = round_sat(prod_p_s5);
			w6_c.d = round_sat(prod_d_s5);
		end
	end

	// output: cautious averaging with the original gains, then P and I floors, skipped when done
	always_comb begin
		p_sum = 33'(w_s6.it.p0) + 33'(w_s6.p);
		i_sum = 33'(w_s6.it.i0) + 33'(w_s6.i);
		d_sum = 33'(w_s6.it.d0) + 33'(w_s6.d);
		p_fin = w_s6.p;
		i_fin = w_s6.i;
		d_fin = w_s6.d;
		if (!w_s6.it.done) begin
			if (mild) begin
				p_fin = p_sum[32:1];
				i_fin = i_sum[32:1];
				d_fin = d_sum[32:1];
			end
			if (p_fin < FLOOR_P) begin
				p_fin = FLOOR_P;
			end
			if (i_fin < FLOOR_I) begin
				i_fin = FLOOR_I;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s1      <= w1_c;
			prod_p_s1 <= 64'(head_item.p0) * 64'(mild ? F_085 : F_090);
			prod_d_s1 <= 64'(head_item.d0) * 64'(mild ? F_130 : F_120);
			prod_i_s1 <= 64'(head_item.i0) * 64'(mild ? F_130 : F_140);
			w_s2      <= w2_c;
			w_s3      <= w_s2;
			prod_p_s3 <= 64'(w_s2.p) * 64'(mild ? F_120 : F_130);
			w_s4      <= w4_c;
			w_s5      <= w_s4;
			prod_p_s5 <= 64'(w_s4.p) * 64'(mild ? F_070 : F_080);
			prod_d_s5 <= 64'(w_s4.d) * 64'(mild ? F_150 : F_130);
			w_s6      <= w6_c;
			p_q       <= p_fin;
			i_q       <= i_fin;
			d_q       <= d_fin;
			it_q      <= w_s6.it;
		end
	end

	assign out_valid        = out_valid_q;
	assign gain_p_next      = p_q;
	assign gain_i_next      = i_q;
	assign gain_d_next      = d_q;
	assign quality_score    = it_q.score;
	assign tuning_done      = it_q.done;
	assign needs_change     = it_q.change;
	assign oscillation_seen = it_q.osc;
	assign slow_seen        = it_q.slow;
	assign offset_seen      = it_q.offs;
	assign overshoot_seen   = it_q.over;
	assign advice_code      = it_q.advice;

	a_done_untouched: assert property (@(posedge clk) disable iff (!arst_n)
		(v_q[5] && w_s6.it.done) |-> (w_s6.p == w_s6.it.p0 && w_s6.d == w_s6.it.d0
			&& w_s6.i == w_s6.it.i0))
		else $error("done item had its gains scaled");
	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(v_q))
		else $error("pipeline advanced while result held");
	a_slow_offs_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[0] |-> !(w_s1.it.slow && w_s1.it.offs))
		else $error("slow and offset rules both fired");
endmodule

>>> src/rule_based_pid_gain_advisor.sv
// Top level of the rule-based PID gain advisor.
// Uses pidga_pkg; instantiates pidga_front, pidga_queue and pidga_back.
//
// Takes one item of error metrics and current P/I/D gains (all Q16.16) per
// cycle and returns one result per item, in order: suggested gains, a 0..100
// score in Q7.16, done status, rule flags and an advice code. From input
// transfer to result valid an item passes two classification stages, one
// queue slot and six stages of gain scaling (three rule multiplies, each
// followed by round and saturate), then the output register. Sustained rate
// is one item per clock while the result side does not stall; the queue
// between the two halves holds up to DEPTH classified items. Configuration
// writes take effect at the next clock and must be made while no item is in
// flight.
module rule_based_pid_gain_advisor #(
	parameter int DEPTH = pidga_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] mean_error,
	input  logic [31:0] error_spread,
	input  logic [31:0] peak_error,
	input  logic [31:0] time_weighted_error,
	input  logic [31:0] gain_p_now,
	input  logic [31:0] gain_i_now,
	input  logic [31:0] gain_d_now,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] gain_p_next,
	output logic [31:0] gain_i_next,
	output logic [31:0] gain_d_next,
	output logic [22:0] quality_score,
	output logic        tuning_done,
	output logic        needs_change,
	output logic        oscillation_seen,
	output logic        slow_seen,
	output logic        offset_seen,
	output logic        overshoot_seen,
	output logic [2:0]  advice_code
);
	import pidga_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	cfg_t          cfg_q;
	logic          push;
	item_t         push_item;
	logic          pop;
	logic          head_valid;
	logic [$bits(item_t)-1:0] head_bits;
	item_t         head_item;
	logic [CW-1:0] queue_count;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.osc_limit    <= 32'd131072;
			cfg_q.slow_limit   <= 32'd327680;
			cfg_q.steady_limit <= 32'd32768;
			cfg_q.cautious     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_OSC_LIMIT:    cfg_q.osc_limit    <= cfg_data;
				CFG_SLOW_LIMIT:   cfg_q.slow_limit   <= cfg_data;
				CFG_STEADY_LIMIT: cfg_q.steady_limit <= cfg_data;
				CFG_CAUTIOUS:     cfg_q.cautious     <= cfg_data[0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	pidga_front #(
		.DEPTH(DEPTH)
	) u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg                 (cfg_q),
		.in_valid            (in_valid),
		.in_stall            (in_stall),
		.mean_error          (mean_error),
		.error_spread        (error_spread),
		.peak_error          (peak_error),
		.time_weighted_error (time_weighted_error),
		.gain_p_now          (gain_p_now),
		.gain_i_now          (gain_i_now),
		.gain_d_now          (gain_d_now),
		.queue_count         (queue_count),
		.push                (push),
		.push_item           (push_item)
	);

	pidga_queue #(
		.WIDTH($bits(item_t)),
		.DEPTH(DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_item),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_bits),
		.count      (queue_count)
	);

	assign head_item = item_t'(head_bits);

	pidga_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg              (cfg_q),
		.head_valid       (head_valid),
		.head_item        (head_item),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.gain_p_next      (gain_p_next),
		.gain_i_next      (gain_i_next),
		.gain_d_next      (gain_d_next),
		.quality_score    (quality_score),
		.tuning_done      (tuning_done),
		.needs_change     (needs_change),
		.oscillation_seen (oscillation_seen),
		.slow_seen        (slow_seen),
		.offset_seen      (offset_seen),
		.overshoot_seen   (overshoot_seen),
		.advice_code      (advice_code)
	);
endmodule
